/* rtl/core/lrf_pkg.sv */
// Shared types and constants for the LCD rectangle fill sequencer.
// Holds the transfer payload structs, mode and header-step codes, and command bytes.
// No dependencies.
`default_nettype none

package lrf_pkg;

  localparam int SIDE_W     = 9;
  localparam int COORD_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [SIDE_W-1:0] SCREEN_W_RST = 9'd240;
  localparam logic [SIDE_W-1:0] SCREEN_H_RST = 9'd320;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [7:0] CMD_COL_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_RECT  = 2'd1,
    MODE_PIXEL = 2'd2,
    MODE_FILL  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    HS_COL_CMD = 4'd0,
    HS_COL_SH  = 4'd1,
    HS_COL_SL  = 4'd2,
    HS_COL_EH  = 4'd3,
    HS_COL_EL  = 4'd4,
    HS_ROW_CMD = 4'd5,
    HS_ROW_SH  = 4'd6,
    HS_ROW_SL  = 4'd7,
    HS_ROW_EH  = 4'd8,
    HS_ROW_EL  = 4'd9,
    HS_MEM_CMD = 4'd10,
    HS_PIXELS  = 4'd11
  } hdr_step_t;

  typedef struct packed {
    mode_t              mode;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [COORD_W-1:0] colour;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       end_of_select;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    mode_t              kind;
    logic [COORD_W-1:0] col_start;
    logic [COORD_W-1:0] col_end;
    logic [COORD_W-1:0] row_start;
    logic [COORD_W-1:0] row_end;
    logic [COORD_W-1:0] colour;
  } win_load_t;

endpackage

`default_nettype wire

/* rtl/core/lcd_rect_fill_sequencer.sv */
// A result passes through the input register and then the result register.
// Throughput: one input item per cycle; the output register holds a result while the next
// item is taken, so only a stalled output slows the input side.
// Each tick while busy yields one byte; requests and idle ticks yield none.
// Reset: synchronous, active low; the sequencer goes idle and the screen becomes 240 x 320.
// Depends on lrf_pkg, lrf_cfg_regs, lrf_clip and lrf_seq.
`default_nettype none

module lcd_rect_fill_sequencer
  import lrf_pkg::*;
#(
  parameter int MAX_SIDE = 320
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SIDE_FULL = (1 << SIDE_W) - 1;
  localparam int SIDE_CAP  = (MAX_SIDE < SIDE_FULL) ? MAX_SIDE : SIDE_FULL;
  localparam int PIX_W     = $clog2(SIDE_CAP * SIDE_CAP + 1);

  logic              in_valid_r;
  in_item_t          in_item_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  logic              advance;
  logic [SIDE_W-1:0] screen_w, screen_h;
  win_load_t         load;
  logic [PIX_W-1:0]  pix_count;
  logic              res_valid;
  out_item_t         res;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (advance && res_valid) begin
      out_item_r <= res;
    end
  end

  lrf_cfg_regs #(
    .MAX_SIDE (MAX_SIDE)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .screen_w  (screen_w),
    .screen_h  (screen_h)
  );

  lrf_clip #(
    .PIX_W (PIX_W)
  ) u_clip (
    .item      (in_item_r),
    .screen_w  (screen_w),
    .screen_h  (screen_h),
    .load      (load),
    .pix_count (pix_count)
  );

  lrf_seq #(
    .PIX_W (PIX_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .mode      (in_item_r.mode),
    .load      (load),
    .pix_count (pix_count),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

/* rtl/core/lrf_cfg_regs.sv */
// Screen size configuration registers; a write keeps the low SIDE_W data bits, capped at the side limit.
// Depends on lrf_pkg.
`default_nettype none

module lrf_cfg_regs
  import lrf_pkg::*;
#(
  parameter int MAX_SIDE = 320
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic      [SIDE_W-1:0]     screen_w,
  output logic      [SIDE_W-1:0]     screen_h
);

  localparam int SIDE_FULL = (1 << SIDE_W) - 1;
  localparam int SIDE_CAP  = (MAX_SIDE < SIDE_FULL) ? MAX_SIDE : SIDE_FULL;
  localparam logic [SIDE_W-1:0] SIDE_CAP_V = SIDE_W'(SIDE_CAP);

  logic [SIDE_W-1:0] screen_w_r, screen_w_nxt;
  logic [SIDE_W-1:0] screen_h_r, screen_h_nxt;
  logic [SIDE_W-1:0] wr_val;

  assign cfg_ready = 1'b1;

  always_comb begin
    wr_val = cfg_data[SIDE_W-1:0];
    if (wr_val > SIDE_CAP_V) begin
      wr_val = SIDE_CAP_V;
    end
    screen_w_nxt = screen_w_r;
    screen_h_nxt = screen_h_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_w_nxt = wr_val;
        REG_SCREEN_HEIGHT: screen_h_nxt = wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= SCREEN_W_RST;
      screen_h_r <= SCREEN_H_RST;
    end else begin
      screen_w_r <= screen_w_nxt;
      screen_h_r <= screen_h_nxt;
    end
  end

  assign screen_w = screen_w_r;
  assign screen_h = screen_h_r;

endmodule

`default_nettype wire

/* rtl/core/lrf_clip.sv */
// Clips a draw request to the screen and forms the window and pixel count.
// Depends on lrf_pkg.
`default_nettype none

module lrf_clip
  import lrf_pkg::*;
#(
  parameter int PIX_W = 17
) (
  input  wire in_item_t          item,
  input  wire logic [SIDE_W-1:0] screen_w,
  input  wire logic [SIDE_W-1:0] screen_h,
  output win_load_t              load,
  output logic      [PIX_W-1:0]  pix_count
);

  logic [COORD_W-1:0]  sw_ext, sh_ext;
  logic                off_screen;
  logic [COORD_W-1:0]  avail_w, avail_h;
  logic [SIDE_W-1:0]   clip_w, clip_h;
  logic [SIDE_W-1:0]   cnt_w, cnt_h;
  logic [2*SIDE_W-1:0] product;

  always_comb begin
    sw_ext     = COORD_W'(screen_w);
    sh_ext     = COORD_W'(screen_h);
    off_screen = (item.pos_x >= sw_ext) || (item.pos_y >= sh_ext);
    avail_w    = sw_ext - item.pos_x;
    avail_h    = sh_ext - item.pos_y;
    clip_w     = (item.rect_width > avail_w) ? avail_w[SIDE_W-1:0]
                                             : item.rect_width[SIDE_W-1:0];
    clip_h     = (item.rect_height > avail_h) ? avail_h[SIDE_W-1:0]
                                              : item.rect_height[SIDE_W-1:0];

    load.valid     = 1'b0;
    load.kind      = item.mode;
    load.col_start = item.pos_x;
    load.row_start = item.pos_y;
    load.col_end   = item.pos_x + COORD_W'(clip_w) - COORD_W'(1);
    load.row_end   = item.pos_y + COORD_W'(clip_h) - COORD_W'(1);
    load.colour    = item.colour;
    cnt_w          = clip_w;
    cnt_h          = clip_h;

    case (item.mode)
      MODE_FILL: begin
        load.valid     = (screen_w != '0) && (screen_h != '0);
        load.col_start = '0;
        load.row_start = '0;
        load.col_end   = COORD_W'(screen_w - SIDE_W'(1));
        load.row_end   = COORD_W'(screen_h - SIDE_W'(1));
        cnt_w          = screen_w;
        cnt_h          = screen_h;
      end
      MODE_PIXEL: begin
        load.valid   = !off_screen;
        load.col_end = item.pos_x + COORD_W'(1);
        load.row_end = item.pos_y + COORD_W'(1);
        cnt_w        = SIDE_W'(1);
        cnt_h        = SIDE_W'(1);
      end
      MODE_RECT: begin
        load.valid = !off_screen && (clip_w != '0) && (clip_h != '0);
      end
      default: begin
        load.valid = 1'b0;
      end
    endcase

    product   = cnt_w * cnt_h;
    pix_count = product[PIX_W-1:0];
  end

endmodule

`default_nettype wire

/* rtl/core/lrf_seq.sv */
// Byte sequencer: holds the loaded window and emits header and colour bytes on ticks.
// Depends on lrf_pkg.
`default_nettype none

module lrf_seq
  import lrf_pkg::*;
#(
  parameter int PIX_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire mode_t            mode,
  input  wire win_load_t        load,
  input  wire logic [PIX_W-1:0] pix_count,
  output logic                  res_valid,
  output out_item_t             res
);

  logic               busy_r, busy_nxt;
  hdr_step_t          step_r, step_nxt;
  mode_t              kind_r, kind_nxt;
  logic [COORD_W-1:0] col_start_r, col_start_nxt;
  logic [COORD_W-1:0] col_end_r, col_end_nxt;
  logic [COORD_W-1:0] row_start_r, row_start_nxt;
  logic [COORD_W-1:0] row_end_r, row_end_nxt;
  logic [COORD_W-1:0] colour_r, colour_nxt;
  logic [PIX_W-1:0]   pix_left_r, pix_left_nxt;
  logic               low_r, low_nxt;

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    kind_nxt      = kind_r;
    col_start_nxt = col_start_r;
    col_end_nxt   = col_end_r;
    row_start_nxt = row_start_r;
    row_end_nxt   = row_end_r;
    colour_nxt    = colour_r;
    pix_left_nxt  = pix_left_r;
    low_nxt       = low_r;
    res_valid     = 1'b0;
    res           = '0;
    if (advance) begin
      if (mode != MODE_TICK) begin
        if (!busy_r && load.valid) begin
          busy_nxt      = 1'b1;
          step_nxt      = HS_COL_CMD;
          kind_nxt      = load.kind;
          col_start_nxt = load.col_start;
          col_end_nxt   = load.col_end;
          row_start_nxt = load.row_start;
          row_end_nxt   = load.row_end;
          colour_nxt    = load.colour;
          pix_left_nxt  = pix_count;
          low_nxt       = 1'b0;
        end
      end else if (busy_r) begin
        res_valid   = 1'b1;
        res.is_data = 1'b1;
        case (step_r)
          HS_COL_CMD: begin
            res.out_byte = CMD_COL_SET;
            res.is_data  = 1'b0;
            step_nxt     = HS_COL_SH;
          end
          HS_COL_SH: begin
            res.out_byte = col_start_r[15:8];
            step_nxt     = HS_COL_SL;
          end
          HS_COL_SL: begin
            res.out_byte = col_start_r[7:0];
            step_nxt     = HS_COL_EH;
          end
          HS_COL_EH: begin
            res.out_byte = col_end_r[15:8];
            step_nxt     = HS_COL_EL;
          end
          HS_COL_EL: begin
            res.out_byte = col_end_r[7:0];
            step_nxt     = HS_ROW_CMD;
          end
          HS_ROW_CMD: begin
            res.out_byte = CMD_ROW_SET;
            res.is_data  = 1'b0;
            step_nxt     = HS_ROW_SH;
          end
          HS_ROW_SH: begin
            res.out_byte = row_start_r[15:8];
            step_nxt     = HS_ROW_SL;
          end
          HS_ROW_SL: begin
            res.out_byte = row_start_r[7:0];
            step_nxt     = HS_ROW_EH;
          end
          HS_ROW_EH: begin
            res.out_byte = row_end_r[15:8];
            step_nxt     = HS_ROW_EL;
          end
          HS_ROW_EL: begin
            res.out_byte = row_end_r[7:0];
            step_nxt     = HS_MEM_CMD;
          end
          HS_MEM_CMD: begin
            res.out_byte      = CMD_MEM_WRITE;
            res.is_data       = 1'b0;
            res.end_of_select = (kind_r != MODE_PIXEL);
            step_nxt          = HS_PIXELS;
          end
          HS_PIXELS: begin
            if (!low_r) begin
              res.out_byte = colour_r[15:8];
              low_nxt      = 1'b1;
            end else begin
              res.out_byte = colour_r[7:0];
              low_nxt      = 1'b0;
              if (pix_left_r != '0) begin
                pix_left_nxt = pix_left_r - PIX_W'(1);
              end
              if (pix_left_r <= PIX_W'(1)) begin
                res.end_of_select = 1'b1;
                busy_nxt          = 1'b0;
                step_nxt          = HS_COL_CMD;
              end
            end
          end
          default: begin
            step_nxt = HS_COL_CMD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      step_r     <= HS_COL_CMD;
      kind_r     <= MODE_TICK;
      pix_left_r <= '0;
      low_r      <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      step_r     <= step_nxt;
      kind_r     <= kind_nxt;
      pix_left_r <= pix_left_nxt;
      low_r      <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_start_r <= col_start_nxt;
    col_end_r   <= col_end_nxt;
    row_start_r <= row_start_nxt;
    row_end_r   <= row_end_nxt;
    colour_r    <= colour_nxt;
  end

`ifndef SYNTHESIS
  a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> step_r == HS_COL_CMD)
    else $error("sequencer idle with header step not at start");

  a_result_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> busy_r && advance)
    else $error("result produced while sequencer idle");

  a_pixels_pending: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && step_r == HS_PIXELS |-> pix_left_r != '0)
    else $error("colour phase entered with no pixels left");

  a_select_release_place: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.end_of_select |->
      step_r == HS_MEM_CMD || (step_r == HS_PIXELS && low_r))
    else $error("select released at an unexpected byte");

  a_finish_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.end_of_select && step_r == HS_PIXELS |=> !busy_r)
    else $error("sequencer still busy after last colour byte");
`endif

endmodule

`default_nettype wire
